[rtl/kli_pkg.sv]
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types and constants for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kli_pkg;

    localparam int NUM_CH     = 5;
    localparam int EXTRA_FRAC = 16;
    localparam int ACTION_W   = 2;
    localparam int SLOT_W     = 7;
    localparam int STEPS_W    = 10;
    localparam int FRAMES_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int CH_W       = 3;

    localparam logic [STEPS_W-1:0]  STEPS_RESET  = 10'd290;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 8'd0;

    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd1;

    localparam logic [CH_W-1:0] LAST_CH = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_CUR,
        ST_RD_NXT,
        ST_LATCH_NXT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic            accept;
        logic            do_write;
        logic            do_start;
        logic            do_stop;
        logic            do_advance;
        logic            do_segment;
        logic            do_end;
        logic            rd_next;
        logic            latch_cur;
        logic            load_pos;
        logic            latch_nxt;
        logic            div_start;
        logic            store_inc;
        logic [CH_W-1:0] ch;
        logic            capture;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                play;
        logic                can_start;
        logic                step_done;
        logic                last_seg;
        logic                div_done;
    } status_t;

endpackage

`default_nettype wire

[rtl/kli_item_if.sv]
// ----------------------------------------------------------------------------
// kli_item_if / kli_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface kli_item_if #(parameter int ANGLE_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [6:0]                   frame_slot;
    logic signed [ANGLE_BITS-1:0] angle_a;
    logic signed [ANGLE_BITS-1:0] angle_b;
    logic signed [ANGLE_BITS-1:0] angle_c;
    logic signed [ANGLE_BITS-1:0] angle_d;
    logic signed [ANGLE_BITS-1:0] angle_e;

    modport source (output valid, action, frame_slot, angle_a, angle_b, angle_c,
                    angle_d, angle_e, input ready);
    modport sink   (input valid, action, frame_slot, angle_a, angle_b, angle_c,
                    angle_d, angle_e, output ready);
endinterface

interface kli_result_if #(parameter int ANGLE_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] out_a;
    logic signed [ANGLE_BITS-1:0] out_b;
    logic signed [ANGLE_BITS-1:0] out_c;
    logic signed [ANGLE_BITS-1:0] out_d;
    logic signed [ANGLE_BITS-1:0] out_e;
    logic                         playing;
    logic                         finished;

    modport source (output valid, out_a, out_b, out_c, out_d, out_e, playing, finished,
                    input ready);
    modport sink   (input valid, out_a, out_b, out_c, out_d, out_e, playing, finished,
                    output ready);
endinterface

`default_nettype wire

[rtl/kli_div.sv]
// ----------------------------------------------------------------------------
// kli_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_div #(
    parameter int WIDTH  = 41,
    parameter int DIV_W  = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic      [WIDTH-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[WIDTH-1]};
        trial     = shifted - {1'b0, divisor};
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            if (!trial[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

[rtl/kli_datapath.sv]
// ----------------------------------------------------------------------------
// kli_datapath
// Keyframe store, channel accumulators, increment divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_datapath #(
    parameter int MAX_KEYFRAMES = 128,
    parameter int ANGLE_BITS    = 24
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       cfg_we,
    input  wire logic [kli_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [kli_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  wire logic [kli_pkg::ACTION_W-1:0]               action,
    input  wire logic [kli_pkg::SLOT_W-1:0]                 frame_slot,
    input  wire logic [kli_pkg::NUM_CH-1:0][ANGLE_BITS-1:0] angle_in,
    input  wire kli_pkg::cmd_t                              cmd,
    output kli_pkg::status_t                                status,
    output logic      [kli_pkg::NUM_CH-1:0][ANGLE_BITS-1:0] out_angle,
    output logic                                            playing,
    output logic                                            finished
);

    import kli_pkg::*;

    localparam int AW    = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int ACC_W = ANGLE_BITS + EXTRA_FRAC + 1;
    localparam int ROW_W = NUM_CH * ANGLE_BITS;
    localparam int UW    = (AW + 2 > FRAMES_W) ? AW + 2 : FRAMES_W;
    localparam int SLW   = (AW > SLOT_W) ? AW : SLOT_W;

    logic [STEPS_W-1:0]  steps_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [ACTION_W-1:0] act_reg;
    logic [SLW-1:0]      slot_reg;
    logic [ROW_W-1:0]    wr_row_reg;
    logic [ROW_W-1:0]    mem [MAX_KEYFRAMES];
    logic [ROW_W-1:0]    rd_q_reg;
    logic [ROW_W-1:0]    cur_row_reg;
    logic [ROW_W-1:0]    nxt_row_reg;
    logic [ACC_W-1:0]    pos_reg [NUM_CH];
    logic [ACC_W-1:0]    inc_reg [NUM_CH];
    logic [AW-1:0]       seg_reg;
    logic [STEPS_W-1:0]  step_reg;
    logic                play_reg;
    logic                fin_reg;
    logic                neg_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic                out_play_reg;
    logic                out_fin_reg;

    logic [AW-1:0]         rd_addr;
    logic [UW-1:0]         frames_ext;
    logic [UW-1:0]         used;
    logic                  slot_ok;
    logic [ANGLE_BITS-1:0] cur_sel;
    logic [ANGLE_BITS-1:0] nxt_sel;
    logic [ANGLE_BITS:0]   diff;
    logic [ANGLE_BITS:0]   diff_mag;
    logic [ACC_W-1:0]      dividend;
    logic [ACC_W-1:0]      quotient;
    logic [ACC_W-1:0]      inc_val;
    logic                  div_done;
    logic [ROW_W-1:0]      sat_row;

    assign frames_ext = UW'(frames_reg);
    assign used       = (frames_ext > UW'(MAX_KEYFRAMES)) ? UW'(MAX_KEYFRAMES) : frames_ext;
    assign slot_ok    = (32'(slot_reg) < MAX_KEYFRAMES);
    assign rd_addr    = cmd.rd_next ? (seg_reg + AW'(1)) : seg_reg;

    assign cur_sel  = cur_row_reg[cmd.ch*ANGLE_BITS +: ANGLE_BITS];
    assign nxt_sel  = nxt_row_reg[cmd.ch*ANGLE_BITS +: ANGLE_BITS];
    assign diff     = {nxt_sel[ANGLE_BITS-1], nxt_sel} - {cur_sel[ANGLE_BITS-1], cur_sel};
    assign diff_mag = diff[ANGLE_BITS] ? (~diff + 1'b1) : diff;
    assign dividend = {diff_mag, {EXTRA_FRAC{1'b0}}};
    assign inc_val  = (steps_reg == '0) ? '0 : (neg_reg ? (~quotient + 1'b1) : quotient);

    kli_div #(
        .WIDTH (ACC_W),
        .DIV_W (STEPS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (steps_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            logic [ANGLE_BITS:0] sh;
            sh = pos_reg[i][ACC_W-1:EXTRA_FRAC];
            if (sh[ANGLE_BITS] != sh[ANGLE_BITS-1])
                sat_row[i*ANGLE_BITS +: ANGLE_BITS] =
                    sh[ANGLE_BITS] ? {1'b1, {(ANGLE_BITS-1){1'b0}}}
                                   : {1'b0, {(ANGLE_BITS-1){1'b1}}};
            else
                sat_row[i*ANGLE_BITS +: ANGLE_BITS] = sh[ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= STEPS_RESET;
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEPS:  steps_reg  <= cfg_data[STEPS_W-1:0];
                REG_FRAMES: frames_reg <= cfg_data[FRAMES_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                pos_reg[i] <= '0;
                inc_reg[i] <= '0;
            end
            seg_reg  <= '0;
            step_reg <= '0;
            play_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
                fin_reg <= 1'b0;
            if (cmd.do_start)
            begin
                seg_reg  <= '0;
                step_reg <= '0;
                play_reg <= 1'b1;
            end
            if (cmd.do_stop)
                play_reg <= 1'b0;
            if (cmd.do_advance)
            begin
                for (int i = 0; i < NUM_CH; i++)
                    pos_reg[i] <= pos_reg[i] + inc_reg[i];
                step_reg <= step_reg + STEPS_W'(1);
            end
            if (cmd.do_segment)
            begin
                seg_reg  <= seg_reg + AW'(1);
                step_reg <= '0;
            end
            if (cmd.do_end)
            begin
                seg_reg  <= '0;
                play_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
            if (cmd.load_pos)
            begin
                for (int i = 0; i < NUM_CH; i++)
                    pos_reg[i] <= {rd_q_reg[i*ANGLE_BITS + ANGLE_BITS - 1],
                                   rd_q_reg[i*ANGLE_BITS +: ANGLE_BITS],
                                   {EXTRA_FRAC{1'b0}}};
            end
            if (cmd.store_inc)
                inc_reg[cmd.ch] <= inc_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg    <= action;
            slot_reg   <= SLW'(frame_slot);
            wr_row_reg <= angle_in;
        end
        if (cmd.do_write && slot_ok)
            mem[slot_reg[AW-1:0]] <= wr_row_reg;
        rd_q_reg <= mem[rd_addr];
        if (cmd.latch_cur)
            cur_row_reg <= rd_q_reg;
        if (cmd.latch_nxt)
            nxt_row_reg <= rd_q_reg;
        if (cmd.div_start)
            neg_reg <= diff[ANGLE_BITS];
        if (cmd.capture)
        begin
            out_row_reg  <= sat_row;
            out_play_reg <= play_reg;
            out_fin_reg  <= fin_reg;
        end
    end

    assign status.action    = act_reg;
    assign status.play      = play_reg;
    assign status.can_start = (used > UW'(1));
    assign status.step_done = (step_reg >= steps_reg);
    assign status.last_seg  = ((UW'(seg_reg) + UW'(2)) >= used);
    assign status.div_done  = div_done;

    assign out_angle = out_row_reg;
    assign playing   = out_play_reg;
    assign finished  = out_fin_reg;

endmodule

`default_nettype wire

[rtl/kli_ctrl.sv]
// ----------------------------------------------------------------------------
// kli_ctrl
// Sequencer: item decode, keyframe reads, increment divisions, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire kli_pkg::status_t status,
    output kli_pkg::cmd_t         cmd
);

    import kli_pkg::*;

    state_t          state_reg, state_next;
    logic            start_reg, start_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.ch         = ch_reg;
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_RESULT;
                start_next = 1'b0;
                unique case (status.action)
                    ACT_WRITE:
                        cmd.do_write = 1'b1;
                    ACT_TOGGLE:
                    begin
                        if (!status.play && status.can_start)
                        begin
                            cmd.do_start = 1'b1;
                            start_next   = 1'b1;
                            state_next   = ST_RD_CUR;
                        end
                        else
                            cmd.do_stop = 1'b1;
                    end
                    ACT_TICK:
                    begin
                        if (status.play)
                        begin
                            if (!status.step_done)
                                cmd.do_advance = 1'b1;
                            else if (status.last_seg)
                                cmd.do_end = 1'b1;
                            else
                            begin
                                cmd.do_segment = 1'b1;
                                state_next     = ST_RD_CUR;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_RD_CUR:
                state_next = ST_RD_NXT;
            ST_RD_NXT:
            begin
                cmd.rd_next   = 1'b1;
                cmd.latch_cur = 1'b1;
                cmd.load_pos  = start_reg;
                state_next    = ST_LATCH_NXT;
            end
            ST_LATCH_NXT:
            begin
                cmd.latch_nxt = 1'b1;
                ch_next       = '0;
                state_next    = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store_inc = 1'b1;
                    if (ch_reg == LAST_CH)
                        state_next = ST_RESULT;
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

    a_div_start_waits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == ST_DIV_WAIT))
        else $error("divider start not followed by wait");

    a_store_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_inc |-> status.div_done)
        else $error("increment stored without divider result");

    a_valid_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESULT))
        else $error("result valid raised outside result state");

    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ch_reg <= LAST_CH))
        else $error("channel index out of range");

endmodule

`default_nettype wire

[rtl/keyframe_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Five-channel linear keyframe player with a shared increment divider.
// ----------------------------------------------------------------------------
// Write, toggle-stop and plain tick items pass from decode straight to the
// result state. Segment change and playback start read both keyframe rows,
// then five serial divisions by the step count, one quotient bit per cycle.
// One item at a time; the next item is taken while the last result waits.
// Reset clears positions, increments, counters and flags; keyframe store is
// not cleared.
`default_nettype none

module keyframe_linear_interpolator #(
    parameter int MAX_KEYFRAMES = 128,
    parameter int ANGLE_BITS    = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    kli_item_if.sink                                item_in,
    kli_result_if.source                            result_out,
    input  wire logic                               cfg_we,
    input  wire logic [kli_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kli_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import kli_pkg::*;

    cmd_t                                cmd;
    status_t                             status;
    logic [NUM_CH-1:0][ANGLE_BITS-1:0]   angle_in;
    logic [NUM_CH-1:0][ANGLE_BITS-1:0]   out_angle;

    assign angle_in[0] = item_in.angle_a;
    assign angle_in[1] = item_in.angle_b;
    assign angle_in[2] = item_in.angle_c;
    assign angle_in[3] = item_in.angle_d;
    assign angle_in[4] = item_in.angle_e;

    kli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    kli_datapath #(
        .MAX_KEYFRAMES (MAX_KEYFRAMES),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .action     (item_in.action),
        .frame_slot (item_in.frame_slot),
        .angle_in   (angle_in),
        .cmd        (cmd),
        .status     (status),
        .out_angle  (out_angle),
        .playing    (result_out.playing),
        .finished   (result_out.finished)
    );

    assign result_out.out_a = out_angle[0];
    assign result_out.out_b = out_angle[1];
    assign result_out.out_c = out_angle[2];
    assign result_out.out_d = out_angle[3];
    assign result_out.out_e = out_angle[4];

endmodule

`default_nettype wire
